/* rtl/itda_pkg.sv */
// shared types, constants and the power-of-ten table for the integer to ascii converter
package itda_pkg;

	localparam int unsigned NUM_POS = 10;          // decimal positions of a 32-bit magnitude
	localparam int unsigned POS_W   = 4;           // index width for NUM_POS positions
	localparam int unsigned POW_W   = 35;          // holds 10^10 and 8 * 10^9
	localparam int unsigned WSEL_W  = 2;           // selects digit weight 8, 4, 2, 1

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// 10^pos for the decimal positions of a 32-bit magnitude
	function automatic logic [POW_W-1:0] pow10(input logic [POS_W-1:0] pos);
		logic [POW_W-1:0] r;
		case (pos)
			4'd0:    r = 35'd1;
			4'd1:    r = 35'd10;
			4'd2:    r = 35'd100;
			4'd3:    r = 35'd1000;
			4'd4:    r = 35'd10000;
			4'd5:    r = 35'd100000;
			4'd6:    r = 35'd1000000;
			4'd7:    r = 35'd10000000;
			4'd8:    r = 35'd100000000;
			4'd9:    r = 35'd1000000000;
			default: r = 35'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/int_to_decimal_ascii.sv */
// signed 32-bit integer to decimal ascii text converter, one character per transaction
//
// usage:
//   slave channel s_axis_*: one transaction carries one signed 32-bit integer in tdata
//   master channel m_axis_*: one transaction per character, most significant first;
//     a '-' leads negative numbers, zero gives a single '0', no leading zeros;
//     tlast marks the final digit of each number
// operation:
//   the magnitude is cut into digits by one shared compare-and-subtract unit that
//   tries the weights 8, 4, 2 and 1 times 10^pos in turn for each decimal position,
//   ten positions from 10^9 down; a negative number first passes a sign step
//   s_axis_tready is high only while no number is being converted
//   the minus sign goes out from the sign step, which follows acceptance and waits
//   for a free output register; each digit goes out once its last weight is tried
//   and the output register is free
// reset:
//   arst_n clears the sequencer and drops m_axis_tvalid; no partial number survives
// back-pressure:
//   a character waits in the output register until taken; the sequencer freezes on
//   the next character to send until that register frees, so nothing is lost
module int_to_decimal_ascii (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic signed [31:0] s_axis_tdata,   // [31:0] value
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic        [7:0]  m_axis_tdata,   // [7:0] char_code
	output logic               m_axis_tlast
);

	itda_pkg::state_t state_q, state_d;

	logic [31:0]                      mag_q, mag_d;        // remainder still to be cut
	logic [itda_pkg::POS_W-1:0]       pos_q, pos_d;        // decimal position in work
	logic [itda_pkg::WSEL_W-1:0]      wsel_q, wsel_d;      // weight bit under trial
	logic [3:0]                       digit_q, digit_d;    // digit being built
	logic                             started_q, started_d; // a digit went out
	logic                             out_valid_q, out_valid_d;
	logic [7:0]                       out_char_q, out_char_d;
	logic                             out_last_q, out_last_d;

	logic [31:0]                 in_raw;
	logic [itda_pkg::POW_W-1:0]  trial;
	logic                        ge;
	logic [31:0]                 mag_sub;
	logic [3:0]                  digit_new;
	logic                        out_free;
	logic                        emit;

	assign in_raw   = s_axis_tdata;
	assign out_free = !out_valid_q || m_axis_tready;

	// shared unit: compare the remainder against weight * 10^pos and subtract
	assign trial     = itda_pkg::pow10(pos_q) << wsel_q;
	assign ge        = {3'b000, mag_q} >= trial;
	assign mag_sub   = ge ? (mag_q - trial[31:0]) : mag_q;
	assign digit_new = ge ? (digit_q | (4'b0001 << wsel_q)) : digit_q;

	// leading zeros are dropped, the units digit always goes out
	assign emit = started_q || (digit_new != 4'd0) || (pos_q == '0);

	always_comb begin
		state_d     = state_q;
		mag_d       = mag_q;
		pos_d       = pos_q;
		wsel_d      = wsel_q;
		digit_d     = digit_q;
		started_d   = started_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		out_char_d  = out_char_q;
		out_last_d  = out_last_q;
		unique case (state_q)
			itda_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					mag_d     = in_raw[31] ? (32'd0 - in_raw) : in_raw;
					pos_d     = itda_pkg::POS_W'(itda_pkg::NUM_POS - 1);
					wsel_d    = '1;
					digit_d   = 4'd0;
					started_d = 1'b0;
					state_d   = in_raw[31] ? itda_pkg::ST_SIGN : itda_pkg::ST_DIGIT;
				end
			end
			itda_pkg::ST_SIGN: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_char_d  = itda_pkg::ASCII_MINUS;
					out_last_d  = 1'b0;
					state_d     = itda_pkg::ST_DIGIT;
				end
			end
			itda_pkg::ST_DIGIT: begin
				if (wsel_q != '0) begin
					// intermediate weight: refine the digit
					mag_d   = mag_sub;
					digit_d = digit_new;
					wsel_d  = wsel_q - 1'b1;
				end else if (!emit || out_free) begin
					// digit complete: send it or drop a leading zero
					mag_d     = mag_sub;
					started_d = started_q || emit;
					wsel_d    = '1;
					digit_d   = 4'd0;
					pos_d     = pos_q - 1'b1;
					if (emit) begin
						out_valid_d = 1'b1;
						out_char_d  = itda_pkg::ASCII_ZERO | {4'd0, digit_new};
						out_last_d  = (pos_q == '0);
					end
					if (pos_q == '0) begin
						state_d = itda_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = itda_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itda_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			wsel_q      <= '1;
			pos_q       <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			started_q   <= started_d;
			wsel_q      <= wsel_d;
			pos_q       <= pos_d;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		mag_q      <= mag_d;
		digit_q    <= digit_d;
		out_char_q <= out_char_d;
		out_last_q <= out_last_d;
	end

	assign s_axis_tready = (state_q == itda_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

	// remainder always fits below ten units of the current position
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itda_pkg::ST_DIGIT |->
			{3'b000, mag_q} < ((itda_pkg::pow10(pos_q) << 3) + (itda_pkg::pow10(pos_q) << 1)))
		else $error("remainder out of range for current decimal position");

	// only a minus sign or a digit ever leaves
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == itda_pkg::ASCII_MINUS) ||
			(m_axis_tdata >= itda_pkg::ASCII_ZERO && m_axis_tdata <= 8'd57))
		else $error("illegal character code");

	// the sign never closes a number
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata == itda_pkg::ASCII_MINUS) |-> !m_axis_tlast)
		else $error("minus sign marked as last");

	// a negative number goes through the sign step
	a_neg_sign: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[31] |=> state_q == itda_pkg::ST_SIGN)
		else $error("negative number skipped the sign");

endmodule
